// ----- rtl/fsp_pkg.sv -----
package fsp_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 200;
    localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int OP_W    = 2;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int RAND_W  = 2;
    localparam int LEVEL_W = 6;
    localparam int RGB_W   = 24;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(36);

    typedef enum logic [OP_W-1:0] {
        OP_SPREAD = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Addresses and checks derived from one item
    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] tgt_addr;
        logic              in_frame;
        logic              spread_ok;
    } plan_t;

    function automatic logic [RGB_W-1:0] palette_rgb(input logic [LEVEL_W-1:0] lvl);
        logic [RGB_W-1:0] rgb;
        case (lvl)
            6'd0:  rgb = 24'h070707;
            6'd1:  rgb = 24'h1F0707;
            6'd2:  rgb = 24'h2F0F07;
            6'd3:  rgb = 24'h470F07;
            6'd4:  rgb = 24'h571707;
            6'd5:  rgb = 24'h671F07;
            6'd6:  rgb = 24'h771F07;
            6'd7:  rgb = 24'h8F2707;
            6'd8:  rgb = 24'h9F2F07;
            6'd9:  rgb = 24'hAF3F07;
            6'd10: rgb = 24'hBF4707;
            6'd11: rgb = 24'hC74707;
            6'd12: rgb = 24'hDF4F07;
            6'd13: rgb = 24'hDF5707;
            6'd14: rgb = 24'hDF5707;
            6'd15: rgb = 24'hD75F07;
            6'd16: rgb = 24'hD75F07;
            6'd17: rgb = 24'hD7670F;
            6'd18: rgb = 24'hCF6F0F;
            6'd19: rgb = 24'hCF770F;
            6'd20: rgb = 24'hCF7F0F;
            6'd21: rgb = 24'hCF8717;
            6'd22: rgb = 24'hC78717;
            6'd23: rgb = 24'hC78F17;
            6'd24: rgb = 24'hC7971F;
            6'd25: rgb = 24'hBF9F1F;
            6'd26: rgb = 24'hBF9F1F;
            6'd27: rgb = 24'hBFA727;
            6'd28: rgb = 24'hBFA727;
            6'd29: rgb = 24'hBFAF2F;
            6'd30: rgb = 24'hB7AF2F;
            6'd31: rgb = 24'hB7B72F;
            6'd32: rgb = 24'hB7B737;
            6'd33: rgb = 24'hCFCF6F;
            6'd34: rgb = 24'hDFDF9F;
            6'd35: rgb = 24'hEFEFC7;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

// ----- rtl/fsp_ram.sv -----
module fsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- rtl/fsp_addr.sv -----
module fsp_addr (
    input  logic [fsp_pkg::COL_W-1:0]  col,
    input  logic [fsp_pkg::ROW_W-1:0]  row,
    input  logic [fsp_pkg::RAND_W-1:0] rand_sel,
    output fsp_pkg::plan_t             plan
);
    import fsp_pkg::*;

    logic [COL_W:0]  shifted;
    logic [COL_W:0]  tgt_col;
    logic [ADDR_W:0] tgt_wide;

    always_comb
    begin
        shifted  = {1'b0, col} + (COL_W+1)'(1);
        tgt_col  = shifted - {{(COL_W+1-RAND_W){1'b0}}, rand_sel};

        plan.in_frame  = (32'(col) < FRAME_WIDTH) && (32'(row) < FRAME_HEIGHT);
        plan.src_addr  = ADDR_W'(32'(row) * FRAME_WIDTH + 32'(col));
        plan.spread_ok = (row != '0)
                         && (shifted >= {{(COL_W+1-RAND_W){1'b0}}, rand_sel})
                         && (32'(tgt_col) < FRAME_WIDTH);

        // one row up, shifted by 1 - r columns
        tgt_wide = {1'b0, plan.src_addr} + (ADDR_W+1)'(1)
                   - {{(ADDR_W+1-RAND_W){1'b0}}, rand_sel}
                   - (ADDR_W+1)'(FRAME_WIDTH);
        plan.tgt_addr = tgt_wide[ADDR_W-1:0];
    end

endmodule

// ----- rtl/fire_spread_pixel_engine_core.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_stall   | operation, col, row, rand_sel, write_value
// output   | out_valid / out_stall | intensity, color, wrote
//
// Each item passes four steps: capture, address, store read, modify/write.
// The four-step sequencer stalls the input: no item enters before the last one
// has written the store back, so store accesses never overlap.
// The result register frees the core; a stalled result holds the next item in
// its last step until the register drains.
// Reset clears control only; the store holds garbage until written.
module fire_spread_pixel_engine_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [fsp_pkg::OP_W-1:0]     operation,
    input  logic [fsp_pkg::COL_W-1:0]    col,
    input  logic [fsp_pkg::ROW_W-1:0]    row,
    input  logic [fsp_pkg::RAND_W-1:0]   rand_sel,
    input  logic [fsp_pkg::LEVEL_W-1:0]  write_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fsp_pkg::LEVEL_W-1:0]  intensity,
    output logic [fsp_pkg::RGB_W-1:0]    color,
    output logic                         wrote
);
    import fsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_READ = 4'b0100,
        S_MOD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    op_t                 op_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [RAND_W-1:0]   rand_reg;
    logic [LEVEL_W-1:0]  wval_reg;
    plan_t               plan_comb;
    plan_t               plan_reg;

    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  intensity_reg, intensity_next;
    logic [RGB_W-1:0]    color_reg, color_next;
    logic                wrote_reg, wrote_next;

    logic                ram_en;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [LEVEL_W-1:0]  ram_wdata;
    logic [LEVEL_W-1:0]  ram_rdata;

    logic                in_xfer;
    logic                out_load;
    logic [LEVEL_W-1:0]  decay;

    fsp_addr u_addr (
        .col      (col_reg),
        .row      (row_reg),
        .rand_sel (rand_reg),
        .plan     (plan_comb)
    );

    fsp_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_load = (state_reg == S_MOD) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_ADDR;
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_MOD;
            S_MOD:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Result and store write-back of the modify step
    always_comb
    begin
        intensity_next = '0;
        color_next     = '0;
        wrote_next     = 1'b0;
        ram_wdata      = '0;
        ram_addr       = plan_reg.src_addr;
        decay          = {{(LEVEL_W-1){1'b0}}, rand_reg[0]};
        if (plan_reg.in_frame)
        begin
            unique case (op_reg)
                OP_SPREAD:
                begin
                    if (plan_reg.spread_ok)
                    begin
                        intensity_next = (ram_rdata > decay) ? ram_rdata - decay : '0;
                        wrote_next     = 1'b1;
                    end
                end
                OP_READ:
                begin
                    intensity_next = ram_rdata;
                    color_next     = palette_rgb(ram_rdata);
                end
                OP_WRITE:
                begin
                    intensity_next = (wval_reg > TOP_LEVEL) ? TOP_LEVEL : wval_reg;
                    wrote_next     = 1'b1;
                end
                default:
                begin
                    intensity_next = '0;
                end
            endcase
        end
        ram_wdata = intensity_next;
        if (state_reg == S_MOD && op_reg == OP_SPREAD)
        begin
            ram_addr = plan_reg.tgt_addr;
        end
        ram_we = out_load && wrote_next;
        ram_en = (state_reg == S_READ) || ram_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= op_t'(operation);
            col_reg  <= col;
            row_reg  <= row;
            rand_reg <= rand_sel;
            wval_reg <= write_value;
        end
        if (state_reg == S_ADDR)
        begin
            plan_reg <= plan_comb;
        end
        if (out_load)
        begin
            intensity_reg <= intensity_next;
            color_reg     <= color_next;
            wrote_reg     <= wrote_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign intensity = intensity_reg;
    assign color     = color_reg;
    assign wrote     = wrote_reg;

    a_write_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_MOD))
        else $error("store written outside modify step");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_ADDR))
        else $error("accepted item did not start address step");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wrote_reg) |-> (intensity_reg <= TOP_LEVEL))
        else $error("written intensity above top level");

    a_read_before_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) && $past(state_reg == S_READ) |-> $past(ram_en && !ram_we))
        else $error("modify step without store read");

endmodule

// ----- tb/tb_fire_spread_pixel_engine_core.sv -----
`timescale 1ns / 1ps

module tb_fire_spread_pixel_engine_core;

    import fsp_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [RGB_W-1:0] FLAME_RGB [0:36] = '{
        24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
        24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
        24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
        24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
        24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
        24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
        24'hFFFFFF
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [RGB_W-1:0]   rgb;
        logic               wrote;
    } flame_res_t;

    typedef struct {
        op_t                op;
        logic [COL_W-1:0]   c;
        logic [ROW_W-1:0]   r;
        logic [RAND_W-1:0]  rs;
        logic [LEVEL_W-1:0] wv;
        bit                 typed;
        flame_res_t         res;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      operation;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [RAND_W-1:0]    rand_sel;
    logic [LEVEL_W-1:0]   write_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [LEVEL_W-1:0]   intensity;
    logic [RGB_W-1:0]     color;
    logic                 wrote;

    // Shadow of the frame store and a map of the pixels written so far
    logic [LEVEL_W-1:0]   heat_mem   [0:STORE_DEPTH-1];
    bit                   heat_known [0:STORE_DEPTH-1];

    flame_res_t           pending_q [$];
    stim_row_t            directed_q [$];
    flame_res_t           seen_want;

    int                   err_count = 0;
    int                   useful_items = 0;
    bit                   steady = 1'b0;
    logic                 hold_off_req;
    bit                   hold_done = 1'b0;
    bit                   stall_on = 1'b0;
    int                   stall_left = 0;
    int                   idle_cycles = 0;

    fire_spread_pixel_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .col         (col),
        .row         (row),
        .rand_sel    (rand_sel),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .intensity   (intensity),
        .color       (color),
        .wrote       (wrote)
    );

    always #1 clk = ~clk;

    function automatic flame_res_t fire_step(op_t op, logic [COL_W-1:0] c,
                                             logic [ROW_W-1:0] r, logic [RAND_W-1:0] rs,
                                             logic [LEVEL_W-1:0] wv);
        flame_res_t res;
        int         addr;
        int         tgt_col;
        int         tgt_addr;
        int         src;
        res = '0;
        if (int'(c) < FRAME_WIDTH && int'(r) < FRAME_HEIGHT)
        begin
            addr = int'(r) * FRAME_WIDTH + int'(c);
            case (op)
                OP_SPREAD:
                begin
                    tgt_col = int'(c) + 1 - int'(rs);
                    if (r != 0 && tgt_col >= 0 && tgt_col < FRAME_WIDTH)
                    begin
                        src = int'(heat_mem[addr]);
                        res.level = (src > int'(rs[0])) ? LEVEL_W'(src - int'(rs[0])) : '0;
                        tgt_addr = (int'(r) - 1) * FRAME_WIDTH + tgt_col;
                        heat_mem[tgt_addr] = res.level;
                        heat_known[tgt_addr] = 1'b1;
                        res.wrote = 1'b1;
                    end
                end
                OP_READ:
                begin
                    res.level = heat_mem[addr];
                    res.rgb = FLAME_RGB[(res.level > TOP_LEVEL) ? 36 : int'(res.level)];
                end
                OP_WRITE:
                begin
                    res.level = (wv > TOP_LEVEL) ? TOP_LEVEL : wv;
                    heat_mem[addr] = res.level;
                    heat_known[addr] = 1'b1;
                    res.wrote = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic add_row(op_t op, int c, int r, int rs, int wv, bit typed = 1'b0,
                           int lvl = 0, int rgb = 0, bit wr = 1'b0);
        stim_row_t entry;
        entry.op = op;
        entry.c = COL_W'(c);
        entry.r = ROW_W'(r);
        entry.rs = RAND_W'(rs);
        entry.wv = LEVEL_W'(wv);
        entry.typed = typed;
        entry.res = '{LEVEL_W'(lvl), RGB_W'(rgb), wr};
        directed_q.push_back(entry);
    endtask

    // Offer one item, hold it until the transfer, then record what must come back
    task automatic offer_item(op_t op, logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                              logic [RAND_W-1:0] rs, logic [LEVEL_W-1:0] wv,
                              bit typed, flame_res_t typed_res);
        int         gap;
        flame_res_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        col         <= c;
        row         <= r;
        rand_sel    <= rs;
        write_value <= wv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = fire_step(op, c, r, rs, wv);
        pending_q.push_back(typed ? typed_res : res);
        if (int'(c) < FRAME_WIDTH && int'(r) < FRAME_HEIGHT && op != OP_NOP)
            useful_items++;
    endtask

    // Receiver: check each transfer, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with nothing pending: intensity %0d color %06h wrote %0d",
                       intensity, color, wrote);
                err_count++;
            end
            else
            begin
                seen_want = pending_q.pop_front();
                if (intensity !== seen_want.level)
                begin
                    $error("intensity: expected %0d, got %0d", seen_want.level, intensity);
                    err_count++;
                end
                if (color !== seen_want.rgb)
                begin
                    $error("color: expected %06h, got %06h", seen_want.rgb, color);
                    err_count++;
                end
                if (wrote !== seen_want.wrote)
                begin
                    $error("wrote: expected %0d, got %0d", seen_want.wrote, wrote);
                    err_count++;
                end
            end
        end
        if (hold_off_req && !hold_done)
        begin
            hold_done = 1'b1;
            stall_on = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        else if (stall_left == 0)
        begin
            stall_on = !stall_on;
            if (stall_on)
                stall_left = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 3)
                                                          : $urandom_range(20, 50);
            else
                stall_left = ($urandom_range(0, 99) < 25) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 6);
        end
        stall_left--;
        out_stall <= stall_on;
    end

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int        c0;
        int        r0;
        int        w;
        int        h;
        int        cc;
        int        rr;
        int        n;
        int        v;
        op_t       op;
        stim_row_t entry;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        operation    <= OP_NOP;
        col          <= '0;
        row          <= '0;
        rand_sel     <= '0;
        write_value  <= '0;
        out_stall    <= 1'b0;
        hold_off_req <= 1'b0;

        // Corners and edges, saturation, skipped spreads, out-of-frame and idle items
        add_row(OP_WRITE,  0,   199, 0, 63, 1'b1, 36, 0, 1'b1);
        add_row(OP_READ,   0,   199, 0, 0,  1'b1, 36, 24'hFFFFFF, 1'b0);
        add_row(OP_WRITE,  319, 199, 3, 0,  1'b1, 0, 0, 1'b1);
        add_row(OP_READ,   319, 199, 0, 0,  1'b1, 0, 24'h070707, 1'b0);
        add_row(OP_WRITE,  5,   0,   0, 35, 1'b1, 35, 0, 1'b1);
        add_row(OP_READ,   5,   0,   0, 0,  1'b1, 35, 24'hEFEFC7, 1'b0);
        add_row(OP_SPREAD, 5,   0,   1, 0,  1'b1);
        add_row(OP_SPREAD, 0,   199, 2, 0,  1'b1);
        add_row(OP_SPREAD, 0,   199, 3, 0,  1'b1);
        add_row(OP_SPREAD, 0,   199, 1, 0,  1'b1, 35, 0, 1'b1);
        add_row(OP_SPREAD, 0,   199, 0, 0,  1'b1, 36, 0, 1'b1);
        add_row(OP_READ,   1,   198, 0, 0,  1'b1, 36, 24'hFFFFFF, 1'b0);
        add_row(OP_SPREAD, 319, 199, 0, 0,  1'b1);
        add_row(OP_SPREAD, 319, 199, 1, 0,  1'b1, 0, 0, 1'b1);
        add_row(OP_READ,   319, 198, 0, 0,  1'b1, 0, 24'h070707, 1'b0);
        add_row(OP_WRITE,  320, 0,   0, 5,  1'b1);
        add_row(OP_READ,   511, 255, 3, 63, 1'b1);
        add_row(OP_SPREAD, 10,  200, 2, 0,  1'b1);
        add_row(OP_WRITE,  0,   255, 0, 20, 1'b1);
        add_row(OP_NOP,    0,   199, 3, 63, 1'b1);
        add_row(OP_WRITE,  2,   199, 0, 34, 1'b1, 34, 0, 1'b1);
        add_row(OP_READ,   2,   199, 0, 0,  1'b1, 34, 24'hDFDF9F, 1'b0);
        add_row(OP_WRITE,  3,   199, 0, 37, 1'b1, 36, 0, 1'b1);
        add_row(OP_SPREAD, 2,   199, 3, 0);
        add_row(OP_READ,   0,   198, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
        begin
            entry = directed_q[i];
            offer_item(entry.op, entry.c, entry.r, entry.rs, entry.wv, entry.typed, entry.res);
        end

        // Long receiver hold-off while the first episode streams in back to back
        hold_off_req <= 1'b1;
        steady = 1'b1;
        while (useful_items < RANDOM_ITEMS + directed_q.size())
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                w = $urandom_range(1, 4);
                h = $urandom_range(2, 5);
                v = $urandom_range(0, 9);
                c0 = (v < 2) ? 0 : (v < 4) ? FRAME_WIDTH - w : $urandom_range(0, FRAME_WIDTH - w);
                v = $urandom_range(0, 9);
                r0 = (v < 2) ? 0 : (v < 4) ? FRAME_HEIGHT - h : $urandom_range(0, FRAME_HEIGHT - h);
                // Seed: cold above, hot bottom row, with some noise in the values
                for (cc = c0; cc < c0 + w; cc++)
                    for (rr = r0; rr < r0 + h; rr++)
                    begin
                        if ($urandom_range(0, 99) < 70)
                            v = (rr == r0 + h - 1) ? 36 : 0;
                        else
                            v = $urandom_range(0, 63);
                        offer_item(OP_WRITE, COL_W'(cc), ROW_W'(rr),
                                   RAND_W'($urandom_range(0, 3)), LEVEL_W'(v), 1'b0, '0);
                    end
                // Spread column by column, row by row inside the column
                for (cc = c0; cc < c0 + w; cc++)
                    for (rr = r0; rr < r0 + h; rr++)
                        offer_item(OP_SPREAD, COL_W'(cc), ROW_W'(rr),
                                   RAND_W'($urandom_range(0, 3)),
                                   LEVEL_W'($urandom_range(0, 63)), 1'b0, '0);
                n = $urandom_range(2, 4);
                repeat (n)
                    offer_item(OP_READ, COL_W'(c0 + $urandom_range(0, w - 1)),
                               ROW_W'(r0 + $urandom_range(0, h - 1)),
                               RAND_W'($urandom_range(0, 3)),
                               LEVEL_W'($urandom_range(0, 63)), 1'b0, '0);
                steady = ($urandom_range(0, 99) < 20);
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    op = op_t'($urandom_range(0, 3));
                    cc = ($urandom_range(0, 1) != 0) ? $urandom_range(0, FRAME_WIDTH - 1)
                                                     : $urandom_range(0, 511);
                    rr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, FRAME_HEIGHT - 1)
                                                     : $urandom_range(0, 255);
                    // Never touch a pixel that holds nothing yet: turn it into a write
                    if (cc < FRAME_WIDTH && rr < FRAME_HEIGHT &&
                        (op == OP_SPREAD || op == OP_READ) &&
                        !heat_known[rr * FRAME_WIDTH + cc])
                        op = OP_WRITE;
                    offer_item(op, COL_W'(cc), ROW_W'(rr), RAND_W'($urandom_range(0, 3)),
                               LEVEL_W'($urandom_range(0, 63)), 1'b0, '0);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
